>>> hw/rtl/quaternion_to_euler_angles_defines.svh
// Assertion macros for the RTL.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTH
`define QTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define QTE_ASSERT_IMPL(lbl, ante, cons) \
  `QTE_ASSERT(lbl, (ante) |-> (cons))
`else
`define QTE_ASSERT(lbl, prop)
`define QTE_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/qte_pkg.sv
package qte_pkg;

  localparam int unsigned QW      = 16;  // input component width
  localparam int unsigned PW      = 32;  // product width
  localparam int unsigned SW      = 34;  // numerator / denominator width
  localparam int unsigned CW      = 36;  // CORDIC vector width
  localparam int unsigned ZW      = 26;  // CORDIC angle accumulator width
  localparam int unsigned AW      = 18;  // rounded angle width
  localparam int unsigned NSTEP   = 20;  // CORDIC iterations
  localparam int unsigned RTW     = 31;  // square root width
  localparam int unsigned RMW     = 61;  // radicand / remainder width
  localparam int unsigned TRW     = 63;  // trial value width
  localparam int unsigned CLAT    = NSTEP + 2;
  localparam int unsigned LAT     = 5 + RTW + CLAT + 1;

  localparam logic signed [ZW-1:0] PI_Z = ZW'(1 << 23);
  localparam logic signed [AW-1:0] HALF_PI = AW'(16384);

  localparam logic signed [ZW-1:0] ATAN_TBL [NSTEP] = '{
    26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669,
    26'sd83416,   26'sd41718,   26'sd20860,  26'sd10430,  26'sd5215,
    26'sd2608,    26'sd1304,    26'sd652,    26'sd326,    26'sd163,
    26'sd81,      26'sd41,      26'sd20,     26'sd10,     26'sd5
  };

  typedef struct packed {
    logic signed [SW-1:0] rn;
    logic signed [SW-1:0] rd;
    logic signed [SW-1:0] yn;
    logic signed [SW-1:0] yd;
    logic signed [SW-1:0] s;
    logic                 sat;
    logic                 clamp;
    logic                 spos;
  } side_t;

  typedef struct packed {
    logic sat;
    logic clamp;
    logic spos;
  } flag_t;

endpackage

>>> hw/rtl/qte_cordic.sv
module qte_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qte_pkg::SW-1:0]       num_i,
  input  logic signed [qte_pkg::SW-1:0]       den_i,
  output logic signed [qte_pkg::AW-1:0]       ang_o
);

  logic signed [qte_pkg::CW-1:0] n_q [qte_pkg::NSTEP+1];
  logic signed [qte_pkg::CW-1:0] d_q [qte_pkg::NSTEP+1];
  logic signed [qte_pkg::ZW-1:0] z_q [qte_pkg::NSTEP+1];
  logic                          zero_q [qte_pkg::NSTEP+1];
  logic signed [qte_pkg::CW-1:0] n_ext, d_ext;
  logic signed [qte_pkg::ZW-1:0] z_rnd;
  logic signed [qte_pkg::AW-1:0] ang_q;

  assign n_ext = qte_pkg::CW'(num_i);
  assign d_ext = qte_pkg::CW'(den_i);

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (num_i == '0) && (den_i == '0);
      if (den_i < 0) begin
        n_q[0] <= -n_ext;
        d_q[0] <= -d_ext;
        z_q[0] <= qte_pkg::PI_Z;
      end else begin
        n_q[0] <= n_ext;
        d_q[0] <= d_ext;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < qte_pkg::NSTEP; i++) begin : g_step
    logic signed [qte_pkg::CW-1:0] dn, dd;
    assign dn = n_q[i] >>> i;
    assign dd = d_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!n_q[i][qte_pkg::CW-1]) begin
          d_q[i+1] <= d_q[i] + dn;
          n_q[i+1] <= n_q[i] - dd;
          z_q[i+1] <= z_q[i] + qte_pkg::ATAN_TBL[i];
        end else begin
          d_q[i+1] <= d_q[i] - dn;
          n_q[i+1] <= n_q[i] + dd;
          z_q[i+1] <= z_q[i] - qte_pkg::ATAN_TBL[i];
        end
      end
    end
  end

  assign z_rnd = z_q[qte_pkg::NSTEP] + qte_pkg::ZW'(128);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= zero_q[qte_pkg::NSTEP] ? '0 : qte_pkg::AW'(z_rnd >>> 8);
    end
  end

  assign ang_o = ang_q;

endmodule

>>> hw/rtl/quaternion_to_euler_angles.sv
// Quaternion (w, x, y, z) in Q1.15 to roll, pitch and yaw, ZYX convention.
// Input request on s_axis: tdata holds quat_w, quat_x, quat_y, quat_z, each
// 16 bits, quat_w in the lowest bits. Output request on m_axis: tdata holds
// roll, pitch, yaw (16 bits signed each, units of pi/32768 rad), roll in the
// lowest bits; tuser carries the pitch_clamped flag.
// Stages: the input register, products, sums, |s| and the radicand; the
// one-bit-per-stage square root that forms the pitch cosine; the
// CORDIC vectoring pipelines (fold, 20 iterations, rounding) and one output
// register. One request enters per cycle while the output does not stall.
// The whole pipeline advances as one: when the output holds a valid result
// that the receiver does not take, every stage holds and s_axis_tready
// drops; nothing is lost or repeated. Bubbles advance freely.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// pitch_clamped is set when |2(wy - zx)| exceeds one; pitch then saturates
// to +/- pi/2.
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] roll, [31:16] pitch, [47:32] yaw
  output logic [47:0] m_axis_tdata,
  // [0] pitch_clamped
  output logic        m_axis_tuser
);

  localparam int unsigned LAT = qte_pkg::LAT;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // input register
  logic signed [qte_pkg::QW-1:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= s_axis_tdata[15:0];
      x_q <= s_axis_tdata[31:16];
      y_q <= s_axis_tdata[47:32];
      z_q <= s_axis_tdata[63:48];
    end
  end

  // products, 2^30 is one
  logic signed [qte_pkg::PW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= w_q * x_q;
      yz_q <= y_q * z_q;
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      wz_q <= w_q * z_q;
      xy_q <= x_q * y_q;
      zz_q <= z_q * z_q;
      wy_q <= w_q * y_q;
      zx_q <= z_q * x_q;
    end
  end

  localparam logic signed [qte_pkg::SW-1:0] ONE = qte_pkg::SW'(1 << 30);

  logic signed [qte_pkg::SW-1:0] sum_rn, sum_rd, sum_yn, sum_yd, sum_s;
  assign sum_rn = (qte_pkg::SW'(wx_q) + qte_pkg::SW'(yz_q)) <<< 1;
  assign sum_rd = ONE - ((qte_pkg::SW'(xx_q) + qte_pkg::SW'(yy_q)) <<< 1);
  assign sum_yn = (qte_pkg::SW'(wz_q) + qte_pkg::SW'(xy_q)) <<< 1;
  assign sum_yd = ONE - ((qte_pkg::SW'(yy_q) + qte_pkg::SW'(zz_q)) <<< 1);
  assign sum_s  = (qte_pkg::SW'(wy_q) - qte_pkg::SW'(zx_q)) <<< 1;

  // side data travels alongside the square root
  localparam int unsigned NSIDE = qte_pkg::RTW + 3;
  qte_pkg::side_t side_q [NSIDE];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].rn    <= sum_rn;
      side_q[0].rd    <= sum_rd;
      side_q[0].yn    <= sum_yn;
      side_q[0].yd    <= sum_yd;
      side_q[0].s     <= sum_s;
      side_q[0].sat   <= (sum_s >= ONE) || (sum_s <= -ONE);
      side_q[0].clamp <= (sum_s > ONE) || (sum_s < -ONE);
      side_q[0].spos  <= sum_s > 0;
    end
  end

  for (genvar k = 1; k < NSIDE; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // |s| below one; zero when saturated so the radicand stays in range
  logic [29:0] abs_q;
  logic signed [qte_pkg::SW-1:0] s_neg;
  assign s_neg = -side_q[0].s;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_q[0].sat) begin
        abs_q <= '0;
      end else if (side_q[0].s[qte_pkg::SW-1]) begin
        abs_q <= s_neg[29:0];
      end else begin
        abs_q <= side_q[0].s[29:0];
      end
    end
  end

  logic [qte_pkg::RMW-1:0] rem_q  [qte_pkg::RTW+1];
  logic [qte_pkg::RTW-1:0] root_q [qte_pkg::RTW+1];
  logic [59:0]             sq;

  assign sq = abs_q * abs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= (qte_pkg::RMW'(1) << 60) - qte_pkg::RMW'(sq);
    end
  end
  assign root_q[0] = '0;

  // one root bit per stage, most significant first
  for (genvar k = 0; k < qte_pkg::RTW; k++) begin : g_sqrt
    localparam int unsigned B = qte_pkg::RTW - 1 - k;
    logic [qte_pkg::TRW-1:0] trial;
    assign trial = (qte_pkg::TRW'(root_q[k]) << (B + 1)) + (qte_pkg::TRW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (qte_pkg::TRW'(rem_q[k]) >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial[qte_pkg::RMW-1:0];
          root_q[k+1] <= root_q[k] | (qte_pkg::RTW'(1) << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  qte_pkg::side_t sd;
  assign sd = side_q[NSIDE-1];

  logic signed [qte_pkg::AW-1:0] roll_ang, pitch_ang, yaw_ang;

  qte_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sd.rn),
    .den_i (sd.rd),
    .ang_o (roll_ang)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sd.s),
    .den_i (qte_pkg::SW'(root_q[qte_pkg::RTW])),
    .ang_o (pitch_ang)
  );

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sd.yn),
    .den_i (sd.yd),
    .ang_o (yaw_ang)
  );

  qte_pkg::flag_t flg_q [qte_pkg::CLAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q[0] <= '{sat: sd.sat, clamp: sd.clamp, spos: sd.spos};
    end
  end
  for (genvar k = 1; k < qte_pkg::CLAT; k++) begin : g_flg
    always_ff @(posedge clk_i) begin
      if (en) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  qte_pkg::flag_t fl;
  assign fl = flg_q[qte_pkg::CLAT-1];

  logic signed [qte_pkg::AW-1:0] pitch_sel;
  always_comb begin
    if (fl.sat) begin
      pitch_sel = fl.spos ? qte_pkg::HALF_PI : -qte_pkg::HALF_PI;
    end else if (pitch_ang > qte_pkg::HALF_PI) begin
      pitch_sel = qte_pkg::HALF_PI;
    end else if (pitch_ang < -qte_pkg::HALF_PI) begin
      pitch_sel = -qte_pkg::HALF_PI;
    end else begin
      pitch_sel = pitch_ang;
    end
  end

  logic [15:0] roll_q, pitch_q, yaw_q;
  logic        clamp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_ang[15:0];
      pitch_q <= pitch_sel[15:0];
      yaw_q   <= yaw_ang[15:0];
      clamp_q <= fl.clamp;
    end
  end

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {yaw_q, pitch_q, roll_q};
  assign m_axis_tuser  = clamp_q;

  `QTE_ASSERT_IMPL(a_pitch_range, m_axis_tvalid,
                   $signed(pitch_q) <= 16'sd16384 && $signed(pitch_q) >= -16'sd16384)
  `QTE_ASSERT_IMPL(a_clamp_sat, m_axis_tvalid && clamp_q,
                   pitch_q == 16'd16384 || pitch_q == 16'hC000)
  `QTE_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `QTE_ASSERT(a_enter, (s_axis_tvalid && s_axis_tready) |=> vld_q[0])

endmodule

>>> verif/quaternion_to_euler_angles_test.sv
module quaternion_to_euler_angles_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic        clamped;
  } angles_t;

  localparam longint OneQ30 = longint'(1) << 30;
  localparam longint PiZ = longint'(1) << 23;
  localparam longint HalfPi = 16384;
  localparam longint AtanLut [20] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [63:0] quat_q[$];
  angles_t     angles_q[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          failed;

  quaternion_to_euler_angles i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  function automatic longint floor_shift(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint vector_angle(longint n, longint d);
    longint acc;
    longint dn;
    longint dd;
    acc = 0;
    if (n == 0 && d == 0) return 0;
    if (d < 0) begin
      d = -d;
      n = -n;
      acc = PiZ;
    end
    for (int i = 0; i < 20; i++) begin
      dn = floor_shift(n, i);
      dd = floor_shift(d, i);
      if (n >= 0) begin
        d += dn;
        n -= dd;
        acc += AtanLut[i];
      end else begin
        d -= dn;
        n += dd;
        acc -= AtanLut[i];
      end
    end
    return floor_shift(acc + 128, 8);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic angles_t euler_angles(logic [63:0] q);
    longint w;
    longint x;
    longint y;
    longint z;
    longint s;
    longint p;
    longint unsigned a;
    angles_t res;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    res.clamped = 1'b0;
    res.roll = 16'(vector_angle(2 * (w * x + y * z), OneQ30 - 2 * (x * x + y * y)));
    res.yaw = 16'(vector_angle(2 * (w * z + x * y), OneQ30 - 2 * (y * y + z * z)));
    s = 2 * (w * y - z * x);
    if (s >= OneQ30 || s <= -OneQ30) begin
      res.clamped = (s > OneQ30 || s < -OneQ30);
      p = (s > 0) ? HalfPi : -HalfPi;
    end else begin
      a = longint'(s < 0 ? -s : s);
      p = vector_angle(s, int_sqrt((longint'(1) << 60) - a * a));
      if (p > HalfPi) p = HalfPi;
      if (p < -HalfPi) p = -HalfPi;
    end
    res.pitch = 16'(p);
    return res;
  endfunction

  function automatic logic [15:0] unit_part();
    // mostly components in [-16384, 16383], some full-range noise
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(32767)) - 16'sd16384);
  endfunction

  function automatic logic [63:0] unit_quat();
    real c [4];
    real norm;
    logic [63:0] q;
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'(int'($urandom_range(20000)) - 10000);
      norm += c[i] * c[i];
    end
    if (norm == 0.0) return {48'd0, 16'sd32767};
    norm = $sqrt(norm);
    for (int i = 0; i < 4; i++) begin
      q[16*i +: 16] = 16'($rtoi(c[i] / norm * 32767.0) + int'($urandom_range(4)) - 2);
    end
    return q;
  endfunction

  function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (quat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= quat_q[0];
        angles_q.push_back(euler_angles(quat_q[0]));
        void'(quat_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t got;
    angles_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[47:32], m_axis_tdata[31:16], m_axis_tdata[15:0],
               m_axis_tuser};
        if (angles_q.size() == 0) begin
          $error("result with nothing pending: %h %b", m_axis_tdata, m_axis_tuser);
          failed = 1'b1;
        end else begin
          want = angles_q.pop_front();
          if (got.roll !== want.roll) begin
            $error("roll: expected %0d got %0d", $signed(want.roll), $signed(got.roll));
            failed = 1'b1;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch: expected %0d got %0d", $signed(want.pitch),
                   $signed(got.pitch));
            failed = 1'b1;
          end
          if (got.yaw !== want.yaw) begin
            $error("yaw: expected %0d got %0d", $signed(want.yaw), $signed(got.yaw));
            failed = 1'b1;
          end
          if (got.clamped !== want.clamped) begin
            $error("pitch_clamped: expected %0b got %0b", want.clamped, got.clamped);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    failed = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 83;
    // directed: extremes, zero, gimbal lock exact, pi wrap
    quat_q.push_back(pack_quat(0, 0, 0, 0));
    quat_q.push_back(pack_quat(32767, 0, 0, 0));
    quat_q.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_q.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_q.push_back(pack_quat(-32768, 32767, -32768, 32767));
    quat_q.push_back(pack_quat(16384, 16384, 16384, 16384));
    quat_q.push_back(pack_quat(16384, -16384, 16384, -16384));
    quat_q.push_back(pack_quat(16384, 16384, 16384, -16384));
    quat_q.push_back(pack_quat(23170, 0, 23170, 0));
    quat_q.push_back(pack_quat(23170, 0, -23170, 0));
    quat_q.push_back(pack_quat(0, 32767, 0, 0));
    quat_q.push_back(pack_quat(0, 0, 0, 32767));
    quat_q.push_back(pack_quat(0, -32768, 0, 0));
    quat_q.push_back(pack_quat(0, 0, 32767, 0));
    quat_q.push_back(pack_quat(0, 23170, 0, 23170));
    quat_q.push_back(pack_quat(32767, 32767, 0, 0));
    quat_q.push_back(pack_quat(-1, 1, -1, 1));
    quat_q.push_back(pack_quat(1, 0, 0, 0));
    for (int i = 0; i < 1500; i++) begin
      if (i == 500) begin
        wait (quat_q.size() == 0);
        send_idle_pct = 83;
        recv_idle_pct = 22;
      end
      if (i == 1000) begin
        wait (quat_q.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(9) < 7) quat_q.push_back(unit_quat());
      else quat_q.push_back({unit_part(), unit_part(), unit_part(), unit_part()});
    end
    wait (quat_q.size() == 0);
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    waited = 0;
    while (angles_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (angles_q.size() != 0) begin
      $error("%0d results never arrived", angles_q.size());
      failed = 1'b1;
    end
    repeat (80) @(posedge clk_i);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
